>>> hw/rtl/node_status_cache_assert.svh
// ----------------------------------------------------------------------------
// node_status_cache assertion macros
// Clocked on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef NODE_STATUS_CACHE_ASSERT_SVH
`define NODE_STATUS_CACHE_ASSERT_SVH

// same-cycle implication
`define NSC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define NSC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/nsc_pkg.sv
// ----------------------------------------------------------------------------
// nsc_pkg
// Shared types and constants of the node status cache.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nsc_pkg;

   localparam int unsigned KEY_W       = 64;
   localparam int unsigned MV_W        = 16;
   localparam int unsigned PCT_W       = 8;
   localparam int unsigned TIME_W      = 32;
   localparam int unsigned LIMIT_W     = 5;
   localparam int unsigned MAX_RESULTS = 16;

   localparam logic OP_UPSERT   = 1'b0;
   localparam logic OP_SNAPSHOT = 1'b1;

   typedef struct packed {
      logic [KEY_W-1:0]  key_high;
      logic [KEY_W-1:0]  key_low;
      logic [MV_W-1:0]   millivolts;
      logic [PCT_W-1:0]  percent;
      logic [TIME_W-1:0] stamp;
   } entry_type;

   typedef struct packed {
      logic               operation;
      logic [KEY_W-1:0]   origin_high;
      logic [KEY_W-1:0]   origin_low;
      logic [MV_W-1:0]    millivolts;
      logic [PCT_W-1:0]   percent_plus_one;
      logic [TIME_W-1:0]  time_now;
      logic [LIMIT_W-1:0] result_limit;
   } req_type;

   typedef struct packed {
      logic              has_entry;
      logic [KEY_W-1:0]  node_high;
      logic [KEY_W-1:0]  node_low;
      logic [MV_W-1:0]   entry_millivolts;
      logic [PCT_W-1:0]  entry_percent;
      logic [TIME_W-1:0] age;
      logic              last;
   } rsp_type;

endpackage

>>> hw/rtl/nsc_table.sv
// ----------------------------------------------------------------------------
// nsc_table
// Entry memory with registered read, plus per-entry valid flops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nsc_table #(
   parameter int unsigned ENTRIES = 16,
   parameter int unsigned AW      = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output nsc_pkg::entry_type  rd_data,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  nsc_pkg::entry_type  wr_data,
   output logic [ENTRIES-1:0]  valid_vec
);

   nsc_pkg::entry_type store_ff [ENTRIES];
   nsc_pkg::entry_type rd_data_ff;
   logic [ENTRIES-1:0] valid_ff;
   logic [ENTRIES-1:0] valid_in;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rd_data   = rd_data_ff;
   assign valid_vec = valid_ff;

endmodule

>>> hw/rtl/nsc_ctrl.sv
// ----------------------------------------------------------------------------
// nsc_ctrl
// Scan sequencer: upsert lookup/evict/write-back and snapshot listing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nsc_ctrl #(
   parameter int unsigned ENTRIES = 16,
   parameter int unsigned AW      = 4,
   parameter int unsigned CW      = 5
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  nsc_pkg::req_type    req_beat,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output nsc_pkg::rsp_type    rsp_beat,
   output logic                rd_en,
   output logic [AW-1:0]       rd_addr,
   input  nsc_pkg::entry_type  rd_data,
   output logic                wr_en,
   output logic [AW-1:0]       wr_addr,
   output nsc_pkg::entry_type  wr_data,
   input  logic [ENTRIES-1:0]  valid_vec
);

   typedef enum logic [4:0] {
      ST_IDLE      = 5'b00001,
      ST_UPD_SCAN  = 5'b00010,
      ST_UPD_WRITE = 5'b00100,
      ST_SNP_SCAN  = 5'b01000,
      ST_SNP_EMIT  = 5'b10000
   } state_type;

   localparam logic [CW-1:0] IDX_END = CW'(ENTRIES);

   state_type state_ff, state_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          chk_vld_ff, chk_vld_in;
   logic [AW-1:0] chk_idx_ff, chk_idx_in;
   logic          hit_found_ff, hit_found_in;
   logic [AW-1:0] hit_idx_ff, hit_idx_in;
   logic          free_found_ff, free_found_in;
   logic [AW-1:0] free_idx_ff, free_idx_in;
   logic [AW-1:0] best_idx_ff, best_idx_in;
   logic [nsc_pkg::TIME_W-1:0]  best_time_ff, best_time_in;
   logic [nsc_pkg::LIMIT_W-1:0] count_ff, count_in;
   logic [nsc_pkg::LIMIT_W-1:0] limit_ff, limit_in;
   nsc_pkg::req_type req_ff, req_in;
   logic             rsp_valid_ff, rsp_valid_in;
   nsc_pkg::rsp_type rsp_ff, rsp_in;

   logic                accept;
   logic                rsp_free;
   logic                issue;
   logic                more_above;
   logic                is_last;
   logic [ENTRIES-1:0]  above_vec;
   logic [nsc_pkg::TIME_W-1:0] time_diff;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign issue     = (idx_ff != IDX_END);
   assign above_vec = (valid_vec >> idx_ff) >> 1;
   assign more_above = |above_vec;
   assign is_last   = (nsc_pkg::LIMIT_W'(count_ff + 1'b1) == limit_ff) || !more_above;
   assign time_diff = rd_data.stamp - best_time_ff;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = idx_ff[AW-1:0];
      hit_found_in  = hit_found_ff;
      hit_idx_in    = hit_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      best_idx_in   = best_idx_ff;
      best_time_in  = best_time_ff;
      count_in      = count_ff;
      limit_in      = limit_ff;
      req_in        = req_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      rd_en         = 1'b0;
      rd_addr       = idx_ff[AW-1:0];
      wr_en         = 1'b0;
      wr_addr       = best_idx_ff;
      wr_data.key_high   = req_ff.origin_high;
      wr_data.key_low    = req_ff.origin_low;
      wr_data.millivolts = req_ff.millivolts;
      wr_data.percent    = req_ff.percent_plus_one;
      wr_data.stamp      = req_ff.time_now;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in        = req_beat;
               idx_in        = '0;
               count_in      = '0;
               hit_found_in  = 1'b0;
               free_found_in = 1'b0;
               if (req_beat.result_limit > nsc_pkg::LIMIT_W'(nsc_pkg::MAX_RESULTS)) begin
                  limit_in = nsc_pkg::LIMIT_W'(nsc_pkg::MAX_RESULTS);
               end else begin
                  limit_in = req_beat.result_limit;
               end
               if (req_beat.operation == nsc_pkg::OP_SNAPSHOT) begin
                  state_in = ST_SNP_SCAN;
               end else begin
                  state_in = ST_UPD_SCAN;
               end
            end
         end
         ST_UPD_SCAN: begin
            if (issue) begin
               rd_en      = 1'b1;
               chk_vld_in = 1'b1;
               idx_in     = CW'(idx_ff + 1'b1);
            end
            if (chk_vld_ff) begin
               if (valid_vec[chk_idx_ff] && !hit_found_ff &&
                   rd_data.key_high == req_ff.origin_high &&
                   rd_data.key_low == req_ff.origin_low) begin
                  hit_found_in = 1'b1;
                  hit_idx_in   = chk_idx_ff;
               end
               if (!valid_vec[chk_idx_ff] && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = chk_idx_ff;
               end
               if (chk_idx_ff == '0) begin
                  best_idx_in  = '0;
                  best_time_in = rd_data.stamp;
               end else if (time_diff[nsc_pkg::TIME_W-1]) begin
                  best_idx_in  = chk_idx_ff;
                  best_time_in = rd_data.stamp;
               end
            end
            if (!issue && !chk_vld_ff) begin
               state_in = ST_UPD_WRITE;
            end
         end
         ST_UPD_WRITE: begin
            wr_en = 1'b1;
            if (hit_found_ff) begin
               wr_addr = hit_idx_ff;
            end else if (free_found_ff) begin
               wr_addr = free_idx_ff;
            end
            state_in = ST_IDLE;
         end
         ST_SNP_SCAN: begin
            if (!issue || limit_ff == '0) begin
               if (rsp_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '0;
                  rsp_in.last  = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else if (valid_vec[idx_ff[AW-1:0]]) begin
               rd_en    = 1'b1;
               state_in = ST_SNP_EMIT;
            end else begin
               idx_in = CW'(idx_ff + 1'b1);
            end
         end
         ST_SNP_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in             = 1'b1;
               rsp_in.has_entry         = 1'b1;
               rsp_in.node_high         = rd_data.key_high;
               rsp_in.node_low          = rd_data.key_low;
               rsp_in.entry_millivolts  = rd_data.millivolts;
               rsp_in.entry_percent     = rd_data.percent;
               rsp_in.age               = req_ff.time_now - rd_data.stamp;
               rsp_in.last              = is_last;
               count_in = nsc_pkg::LIMIT_W'(count_ff + 1'b1);
               idx_in   = CW'(idx_ff + 1'b1);
               state_in = is_last ? ST_IDLE : ST_SNP_SCAN;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      chk_idx_ff    <= chk_idx_in;
      hit_found_ff  <= hit_found_in;
      hit_idx_ff    <= hit_idx_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      best_idx_ff   <= best_idx_in;
      best_time_ff  <= best_time_in;
      count_ff      <= count_in;
      limit_ff      <= limit_in;
      req_ff        <= req_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_ff;

endmodule

>>> hw/rtl/node_status_cache.sv
// ----------------------------------------------------------------------------
// node_status_cache
// Per-node battery status table keyed by 128-bit node id.
// ----------------------------------------------------------------------------
// req_*: one beat is an upsert (tuser 0) or a snapshot request (tuser 1).
//   An upsert updates the matching entry, else the first free one, else
//   evicts the stalest; it returns nothing. A snapshot lists used entries,
//   at most result_limit capped at 16, in index order with their ages, tlast
//   on the final beat; an empty listing returns a single beat with tuser 0.
// rsp_*: registered output stage; a stalled beat holds until taken.
// Flow: one request at a time, set by the sequential scan of the entry
//   memory. Upsert: one read per entry, then one write-back. Snapshot:
//   unused entries below the last one listed are skipped, and each entry
//   listed is read, then loaded into the output register; an empty listing
//   with a nonzero limit scans every entry, then emits its beat. A stalled
//   response beat holds the scan until rsp_tready is high.
// Reset clears all valid bits; entry contents are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module node_status_cache #(
   parameter int unsigned ENTRIES = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // origin_high, origin_low, millivolts, percent_plus_one, time_now,
   // result_limit, zero pad
   input  logic [191:0] req_tdata,
   // operation
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // node_high, node_low, entry_millivolts, entry_percent, age
   output logic [183:0] rsp_tdata,
   // has_entry
   output logic         rsp_tuser,
   output logic         rsp_tlast
);

   localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned CW = $clog2(ENTRIES + 1);

   nsc_pkg::req_type    req_beat;
   nsc_pkg::rsp_type    rsp_beat;
   nsc_pkg::entry_type  rd_data;
   nsc_pkg::entry_type  wr_data;
   logic                rd_en;
   logic                wr_en;
   logic [AW-1:0]       rd_addr;
   logic [AW-1:0]       wr_addr;
   logic [ENTRIES-1:0]  valid_vec;

   assign req_beat.operation        = req_tuser;
   assign req_beat.origin_high      = req_tdata[63:0];
   assign req_beat.origin_low       = req_tdata[127:64];
   assign req_beat.millivolts       = req_tdata[143:128];
   assign req_beat.percent_plus_one = req_tdata[151:144];
   assign req_beat.time_now         = req_tdata[183:152];
   assign req_beat.result_limit     = req_tdata[188:184];

   assign rsp_tdata = {rsp_beat.age, rsp_beat.entry_percent, rsp_beat.entry_millivolts,
                       rsp_beat.node_low, rsp_beat.node_high};
   assign rsp_tuser = rsp_beat.has_entry;
   assign rsp_tlast = rsp_beat.last;

   nsc_ctrl #(
      .ENTRIES (ENTRIES),
      .AW      (AW),
      .CW      (CW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_beat  (req_beat),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_beat  (rsp_beat),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .valid_vec (valid_vec)
   );

   nsc_table #(
      .ENTRIES (ENTRIES),
      .AW      (AW)
   ) u_table (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .valid_vec (valid_vec)
   );

endmodule

>>> hw/rtl/nsc_checker.sv
// ----------------------------------------------------------------------------
// nsc_checker
// Port-level checks of node_status_cache, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "node_status_cache_assert.svh"

module nsc_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [191:0] req_tdata,
   input logic         req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [183:0] rsp_tdata,
   input logic         rsp_tuser,
   input logic         rsp_tlast
);

   logic req_beat;
   logic rsp_stall;
   logic rsp_empty;

   assign req_beat  = req_tvalid && req_tready;
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_empty = rsp_tvalid && !rsp_tuser;

   `NSC_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "stalled response beat changed")
   `NSC_ASSERT_NOW(a_empty_last, rsp_empty, rsp_tlast, "empty snapshot beat without tlast")
   `NSC_ASSERT_NOW(a_empty_zero, rsp_empty, rsp_tdata == '0, "empty snapshot beat carries data")
   `NSC_ASSERT_NEXT(a_one_at_a_time, req_beat, !req_tready, "request taken while busy")

endmodule

bind node_status_cache nsc_checker u_nsc_checker (.*);

>>> tb/sv/node_status_cache_checker.sv
// ----------------------------------------------------------------------------
// node_status_cache_checker
// Watches both stream channels of the node status cache. Each accepted
// request beat goes through a shadow copy of the entry table: upserts update
// it, snapshots queue the listing beats they must produce. Each accepted
// response beat is checked field by field against the oldest queued beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module node_status_cache_checker #(
   parameter int unsigned ENTRIES = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   // origin_high, origin_low, millivolts, percent_plus_one, time_now,
   // result_limit, zero pad
   input  logic [191:0] req_tdata,
   // operation
   input  logic         req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   // node_high, node_low, entry_millivolts, entry_percent, age
   input  logic [183:0] rsp_tdata,
   // has_entry
   input  logic         rsp_tuser,
   input  logic         rsp_tlast,
   output int unsigned  fail_count,
   output int unsigned  pending
);

   logic               slot_used [ENTRIES];
   nsc_pkg::entry_type slot_data [ENTRIES];
   nsc_pkg::rsp_type   listing_q [$];
   int unsigned err_cnt = 0;

   // first slot with a matching id, else first free slot, else stalest (wrap-aware)
   function automatic int unsigned choose_slot(input logic [nsc_pkg::KEY_W-1:0] hi,
                                               input logic [nsc_pkg::KEY_W-1:0] lo);
      int unsigned oldest;
      logic [nsc_pkg::TIME_W-1:0] diff;
      for (int unsigned i = 0; i < ENTRIES; i++)
         if (slot_used[i] && slot_data[i].key_high == hi && slot_data[i].key_low == lo)
            return i;
      for (int unsigned i = 0; i < ENTRIES; i++)
         if (!slot_used[i])
            return i;
      oldest = 0;
      for (int unsigned i = 0; i < ENTRIES; i++) begin
         diff = slot_data[i].stamp - slot_data[oldest].stamp;
         if (diff[nsc_pkg::TIME_W-1])
            oldest = i;
      end
      return oldest;
   endfunction

   task automatic apply_request(input nsc_pkg::req_type r);
      int unsigned slot;
      int unsigned lim;
      int unsigned n;
      nsc_pkg::rsp_type held;
      nsc_pkg::rsp_type beat;
      if (r.operation == nsc_pkg::OP_UPSERT) begin
         slot = choose_slot(r.origin_high, r.origin_low);
         slot_used[slot] = 1'b1;
         slot_data[slot].key_high   = r.origin_high;
         slot_data[slot].key_low    = r.origin_low;
         slot_data[slot].millivolts = r.millivolts;
         slot_data[slot].percent    = r.percent_plus_one;
         slot_data[slot].stamp      = r.time_now;
      end else begin
         lim = (r.result_limit > nsc_pkg::MAX_RESULTS) ? nsc_pkg::MAX_RESULTS
                                                        : r.result_limit;
         n = 0;
         held = '0;
         for (int unsigned i = 0; i < ENTRIES && n < lim; i++) begin
            if (slot_used[i]) begin
               if (n != 0)
                  listing_q.push_back(held);
               beat = '0;
               beat.has_entry        = 1'b1;
               beat.node_high        = slot_data[i].key_high;
               beat.node_low         = slot_data[i].key_low;
               beat.entry_millivolts = slot_data[i].millivolts;
               beat.entry_percent    = slot_data[i].percent;
               beat.age              = r.time_now - slot_data[i].stamp;
               held = beat;
               n++;
            end
         end
         // empty listing is a single all-zero beat with last set
         held.last = 1'b1;
         listing_q.push_back(held);
      end
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         err_cnt++;
         if (err_cnt <= 10)
            $display("%0t: %s mismatch: expected %h, got %h", $realtime, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      nsc_pkg::req_type req;
      nsc_pkg::rsp_type want;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++)
            slot_used[i] = 1'b0;
         listing_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (listing_q.size() == 0) begin
               err_cnt++;
               if (err_cnt <= 10)
                  $display("%0t: response beat with nothing expected: %h", $realtime,
                           rsp_tdata);
            end else begin
               want = listing_q.pop_front();
               check_field("has_entry", want.has_entry, rsp_tuser);
               check_field("node_high", want.node_high, rsp_tdata[63:0]);
               check_field("node_low", want.node_low, rsp_tdata[127:64]);
               check_field("entry_millivolts", want.entry_millivolts, rsp_tdata[143:128]);
               check_field("entry_percent", want.entry_percent, rsp_tdata[151:144]);
               check_field("age", want.age, rsp_tdata[183:152]);
               check_field("last", want.last, rsp_tlast);
            end
         end
         if (req_tvalid && req_tready) begin
            req.operation        = req_tuser;
            req.origin_high      = req_tdata[63:0];
            req.origin_low       = req_tdata[127:64];
            req.millivolts       = req_tdata[143:128];
            req.percent_plus_one = req_tdata[151:144];
            req.time_now         = req_tdata[183:152];
            req.result_limit     = req_tdata[188:184];
            apply_request(req);
         end
      end
      pending    = listing_q.size();
      fail_count = err_cnt;
   end

endmodule

>>> tb/sv/node_status_cache_tb.sv
// ----------------------------------------------------------------------------
// node_status_cache_tb
// Stimulus and verdict for the node status cache. A directed pass covers the
// empty table, filling with wrapping times, id extremes, partial id matches,
// updates, eviction and snapshot limits 0, 5, 16 and 31. Random upserts and
// snapshots over a small id pool then keep the table full and evicting,
// under three idle patterns on the request and response sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module node_status_cache_tb;

   localparam int unsigned ENTRIES     = 16;
   localparam int unsigned POOL        = 24;
   localparam int unsigned STALL_LIMIT = 20000;
   localparam int unsigned TAIL_CYCLES = 2 * ENTRIES + 8;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [191:0] req_tdata;
   logic         req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [183:0] rsp_tdata;
   logic         rsp_tuser;
   logic         rsp_tlast;

   int unsigned fail_count;
   int unsigned pending;
   int unsigned send_idle;
   int unsigned recv_idle;
   int unsigned quiet_cycles;
   logic [63:0] id_high [POOL];
   logic [63:0] id_low  [POOL];
   logic [31:0] now_ms;

   node_status_cache #(.ENTRIES(ENTRIES)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   node_status_cache_checker #(.ENTRIES(ENTRIES)) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles == STALL_LIMIT) begin
         $display("** node_status_cache: FAILED **");
         $finish;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic send_beat(input logic op, input logic [63:0] hi, input logic [63:0] lo,
                            input logic [15:0] mv, input logic [7:0] pct,
                            input logic [31:0] tm, input logic [4:0] lim);
      if ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {3'b000, lim, tm, pct, mv, lo, hi};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic upsert(input int unsigned k, input logic [15:0] mv,
                         input logic [7:0] pct, input logic [31:0] tm);
      send_beat(nsc_pkg::OP_UPSERT, id_high[k], id_low[k], mv, pct, tm, 5'($urandom));
   endtask

   task automatic snapshot(input logic [31:0] tm, input logic [4:0] lim);
      send_beat(nsc_pkg::OP_SNAPSHOT, rand64(), rand64(), 16'($urandom), 8'($urandom),
                tm, lim);
   endtask

   initial begin
      int unsigned r;
      int unsigned k;
      logic [31:0] tm;
      send_idle  = 0;
      recv_idle  = 0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= nsc_pkg::OP_UPSERT;
      for (int i = 0; i < POOL; i++) begin
         id_high[i] = rand64();
         id_low[i]  = rand64();
      end
      id_high[0] = '1;
      id_low[0]  = '1;
      id_high[1] = '0;
      id_low[1]  = '0;
      id_high[3] = id_high[2];   // same upper half, different lower
      id_low[5]  = id_low[4];    // same lower half, different upper
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed
      snapshot(32'h0, 5'd16);
      snapshot(32'($urandom), 5'd0);
      for (int i = 0; i < ENTRIES; i++) begin
         upsert(i, (i == 0) ? 16'hFFFF : (i == 1) ? 16'h0000 : 16'($urandom),
                (i == 0) ? 8'hFF : (i == 1) ? 8'h00 : 8'($urandom),
                32'hFFFF_FFF8 + i);
         if (i == 7)
            snapshot(32'h0000_0004, 5'd16);
      end
      snapshot(32'h0000_0010, 5'd31);
      snapshot(32'h0000_0000, 5'd5);
      upsert(3, 16'h1234, 8'h65, 32'h0000_0020);
      upsert(16, 16'h0BB8, 8'h33, 32'h0000_0030);
      upsert(17, 16'h0CE4, 8'h40, 32'h0000_0030);
      snapshot(32'h0000_0040, 5'd16);
      snapshot(32'h0000_0040, 5'd0);

      // random, three idle patterns
      now_ms = 32'h0000_0040;
      for (int phase = 0; phase < 3; phase++) begin
         send_idle = (phase == 0) ? 23 : (phase == 1) ? 70 : 0;
         recv_idle = (phase == 0) ? 70 : (phase == 1) ? 23 : 0;
         for (int n = 0; n < 25; n++) begin
            r = $urandom_range(99);
            if (r < 5)
               now_ms = $urandom;
            else if (r < 10)
               now_ms += 32'h8000_0000 + $urandom_range(0, 3);
            else if (r >= 40)
               now_ms += $urandom_range(1, 5000);
            if ($urandom_range(99) < 25) begin
               snapshot(now_ms, 5'($urandom_range(31)));
            end else begin
               tm = ($urandom_range(99) < 15) ? 32'($urandom) : now_ms;
               if ($urandom_range(99) < 20) begin
                  send_beat(nsc_pkg::OP_UPSERT, rand64(), rand64(), 16'($urandom),
                            8'($urandom), tm, 5'($urandom));
               end else begin
                  k = $urandom_range(POOL - 1);
                  upsert(k, 16'($urandom), 8'($urandom), tm);
               end
            end
         end
      end
      req_tvalid <= 1'b0;

      @(posedge clock);
      wait (pending == 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("** node_status_cache: PASSED **");
      else
         $display("** node_status_cache: FAILED **");
      $finish;
   end

endmodule
